>>> src/blsph_pkg.sv
// ----------------------------------------------------------------------------
// blsph_pkg
// Shared widths, register codes, reset values and the per-band state word
// of the band level smoother with peak hold.
// ----------------------------------------------------------------------------
package blsph_pkg;

   localparam int NUM_BANDS  = 64;
   localparam int ADDR_W     = $clog2(NUM_BANDS);
   localparam int BAND_W     = 6;
   localparam int LEVEL_W    = 16;
   localparam int COEFF_W    = 16;
   localparam int HOLD_W     = 10;
   localparam int DECAY_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIFF_W     = LEVEL_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = LEVEL_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 2'd2;

   localparam logic [COEFF_W-1:0]        COEFF_RESET = 16'd52429;
   localparam logic [HOLD_W-1:0]         HOLD_RESET  = 10'd63;
   localparam logic [DECAY_W-1:0]        DECAY_RESET = 12'd64;
   localparam logic signed [LEVEL_W-1:0] PEAK_RESET  = -16'sd25600;
   localparam logic signed [SUM_W-1:0]   LEVEL_MIN   = -18'sd32768;
   localparam logic signed [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);

   typedef struct packed {
      logic signed [LEVEL_W-1:0] smoothed;
      logic signed [LEVEL_W-1:0] peak;
      logic [HOLD_W-1:0]         hold;
   } band_state_type;

   localparam int STATE_W = $bits(band_state_type);

   localparam band_state_type RESET_STATE = '{smoothed: '0, peak: PEAK_RESET, hold: '0};

   typedef struct packed {
      logic [COEFF_W-1:0] coeff;
      logic [HOLD_W-1:0]  hold_frames;
      logic [DECAY_W-1:0] decay;
   } csr_type;

endpackage

>>> src/blsph_ram.sv
// ----------------------------------------------------------------------------
// blsph_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module blsph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/blsph_mix.sv
// ----------------------------------------------------------------------------
// blsph_mix
// Old band state selection (bypass, memory or reset value) and the
// smoothing product (old - new) * k.
// ----------------------------------------------------------------------------
module blsph_mix (
   input  blsph_pkg::band_state_type                ram_state,
   input  logic                                     ram_valid,
   input  logic                                     fwd_hit,
   input  blsph_pkg::band_state_type                fwd_state,
   input  logic signed [blsph_pkg::LEVEL_W-1:0]     new_level,
   input  logic [blsph_pkg::COEFF_W-1:0]            coeff,
   output blsph_pkg::band_state_type                old_state,
   output logic signed [blsph_pkg::PROD_W-1:0]      product
);
   import blsph_pkg::*;

   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] coeff_s;

   always_comb begin
      priority if (fwd_hit) begin
         old_state = fwd_state;
      end else if (ram_valid) begin
         old_state = ram_state;
      end else begin
         old_state = RESET_STATE;
      end
   end

   assign diff    = DIFF_W'(old_state.smoothed) - DIFF_W'(new_level);
   assign coeff_s = $signed({1'b0, coeff});
   assign product = diff * coeff_s;

endmodule

>>> src/blsph_peak.sv
// ----------------------------------------------------------------------------
// blsph_peak
// Rounded smoothed level and the peak hold / decay update of one band.
// ----------------------------------------------------------------------------
module blsph_peak (
   input  logic signed [blsph_pkg::LEVEL_W-1:0]     new_level,
   input  logic signed [blsph_pkg::PROD_W-1:0]      product,
   input  blsph_pkg::band_state_type                old_state,
   input  logic [blsph_pkg::HOLD_W-1:0]             hold_frames,
   input  logic [blsph_pkg::DECAY_W-1:0]            decay,
   output blsph_pkg::band_state_type                next_state
);
   import blsph_pkg::*;

   logic signed [PROD_W-1:0]  rounded;
   logic signed [SUM_W-1:0]   sum;
   logic signed [LEVEL_W-1:0] smoothed;
   logic signed [SUM_W-1:0]   peak_dec;
   logic signed [LEVEL_W-1:0] peak_dec_sat;
   logic [HOLD_W-1:0]         hold_dec;
   logic signed [LEVEL_W-1:0] peak_held;

   assign rounded  = product + ROUND_HALF;
   assign sum      = $signed(rounded[PROD_W-1:COEFF_W]) + SUM_W'(new_level);
   assign smoothed = sum[LEVEL_W-1:0];

   assign peak_dec     = SUM_W'(old_state.peak) - $signed(SUM_W'(decay));
   assign peak_dec_sat = (peak_dec < LEVEL_MIN) ? LEVEL_MIN[LEVEL_W-1:0]
                                                : peak_dec[LEVEL_W-1:0];
   assign hold_dec     = (old_state.hold == '0) ? '0 : old_state.hold - 1'b1;
   assign peak_held    = (hold_dec == '0) ? peak_dec_sat : old_state.peak;

   always_comb begin
      next_state.smoothed = smoothed;
      priority if (smoothed > old_state.peak) begin
         next_state.peak = smoothed;
         next_state.hold = hold_frames;
      end else begin
         next_state.hold = hold_dec;
         next_state.peak = (peak_held < smoothed) ? smoothed : peak_held;
      end
   end

endmodule

>>> src/band_level_smoother_peak_hold_top.sv
// ----------------------------------------------------------------------------
// band_level_smoother_peak_hold_top
// Per-band smoothed level, peak hold and peak decay over a band state RAM.
//
// Usage: req_ carries one word per band update (band index, new level in
// signed Q8.8 dB); rsp_ returns one word per request (band, smoothed level,
// peak), in request order. Both channels are valid/ready.
// Path: an accepted word passes the read stage, the update stage and the output register before it is shown on rsp_.
// Throughput: one word per cycle while rsp_ready is high. A word for the
// same band as the word just ahead of it waits while that word is in the read
// stage, as the smoothing multiply needs the finished level of the previous one.
// State: one RAM word per band, read at the accepting edge and written as the
// update stage hands its word on; the last write is bypassed to the read stage.
// Reset: per-band valid flops clear at once, so every band reads smoothed 0,
// peak -100 dB, hold 0; registers return to their defaults. No clearing
// pass; req_ready may rise on the first cycle after reset.
// Stall: a result waits in the output register while req_ words keep
// entering until the two internal stages fill, then req_ready drops.
// Configuration: csr_ writes take effect at once; write only while idle.
// ----------------------------------------------------------------------------
module band_level_smoother_peak_hold_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [blsph_pkg::BAND_W-1:0]             req_band_index,
   input  logic signed [blsph_pkg::LEVEL_W-1:0]     req_new_level_db,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [blsph_pkg::BAND_W-1:0]             rsp_band_out,
   output logic signed [blsph_pkg::LEVEL_W-1:0]     rsp_smoothed_db,
   output logic signed [blsph_pkg::LEVEL_W-1:0]     rsp_peak_db,
   input  logic                                     csr_write_en,
   input  logic [blsph_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [blsph_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import blsph_pkg::*;

   csr_type                   csr_ff, csr_in;

   logic                      s1_valid_ff, s1_valid_in;
   logic [BAND_W-1:0]         s1_band_ff;
   logic                      s1_inrange_ff;
   logic signed [LEVEL_W-1:0] s1_level_ff;
   logic                      rvld_ff;

   logic                      s2_valid_ff, s2_valid_in;
   logic [BAND_W-1:0]         s2_band_ff;
   logic                      s2_inrange_ff;
   logic signed [LEVEL_W-1:0] s2_level_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff;
   band_state_type            s2_old_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]         rsp_band_ff;
   logic signed [LEVEL_W-1:0] rsp_smoothed_ff;
   logic signed [LEVEL_W-1:0] rsp_peak_ff;

   logic                      wr_valid_ff;
   logic [ADDR_W-1:0]         wr_addr_ff;
   band_state_type            wr_state_ff;

   logic [NUM_BANDS-1:0]      bvld_ff, bvld_in;

   logic                      s1_free, s2_free, s3_free;
   logic                      s1_go, s2_go, req_go, hazard, ram_we, req_inrange;
   logic [ADDR_W-1:0]         req_addr, s1_addr, s2_addr;
   logic [STATE_W-1:0]        ram_rdata;
   band_state_type            ram_state, old_state, next_state;
   logic signed [PROD_W-1:0]  product;
   logic                      fwd_hit;

   // advance control
   assign s3_free = !rsp_valid_ff || rsp_ready;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s2_go   = s2_valid_ff && s3_free;
   assign s1_go   = s1_valid_ff && s2_free;

   assign hazard  = (s1_valid_ff && (s1_band_ff == req_band_index)) ||
                    (s2_valid_ff && !s3_free && (s2_band_ff == req_band_index));
   assign req_ready = s1_free && !hazard;
   assign req_go    = req_valid && req_ready;

   assign req_inrange = 32'(req_band_index) < NUM_BANDS;
   assign req_addr    = ADDR_W'(req_band_index);
   assign s1_addr     = ADDR_W'(s1_band_ff);
   assign s2_addr     = ADDR_W'(s2_band_ff);
   assign ram_we      = s2_go && s2_inrange_ff;
   assign fwd_hit     = wr_valid_ff && (wr_addr_ff == s1_addr);
   assign ram_state   = band_state_type'(ram_rdata);

   blsph_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_BANDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s2_addr),
      .wdata (next_state),
      .re    (req_go),
      .raddr (req_addr),
      .rdata (ram_rdata)
   );

   blsph_mix u_mix (
      .ram_state (ram_state),
      .ram_valid (rvld_ff),
      .fwd_hit   (fwd_hit),
      .fwd_state (wr_state_ff),
      .new_level (s1_level_ff),
      .coeff     (csr_ff.coeff),
      .old_state (old_state),
      .product   (product)
   );

   blsph_peak u_peak (
      .new_level   (s2_level_ff),
      .product     (s2_prod_ff),
      .old_state   (s2_old_ff),
      .hold_frames (csr_ff.hold_frames),
      .decay       (csr_ff.decay),
      .next_state  (next_state)
   );

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_COEFF: csr_in.coeff       = csr_wdata[COEFF_W-1:0];
            CSR_HOLD:  csr_in.hold_frames = csr_wdata[HOLD_W-1:0];
            CSR_DECAY: csr_in.decay       = csr_wdata[DECAY_W-1:0];
            default:   csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_go ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      bvld_in      = bvld_ff;
      if (ram_we) begin
         bvld_in[s2_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '{coeff: COEFF_RESET, hold_frames: HOLD_RESET, decay: DECAY_RESET};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
         bvld_ff      <= '0;
      end else begin
         csr_ff       <= csr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bvld_ff      <= bvld_in;
         if (ram_we) begin
            wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_band_ff    <= req_band_index;
         s1_inrange_ff <= req_inrange;
         s1_level_ff   <= req_new_level_db;
         rvld_ff       <= bvld_ff[req_addr];
      end
      if (s1_go) begin
         s2_band_ff    <= s1_band_ff;
         s2_inrange_ff <= s1_inrange_ff;
         s2_level_ff   <= s1_level_ff;
         s2_prod_ff    <= product;
         s2_old_ff     <= old_state;
      end
      if (s2_go) begin
         rsp_band_ff     <= s2_band_ff;
         rsp_smoothed_ff <= s2_inrange_ff ? next_state.smoothed : '0;
         rsp_peak_ff     <= s2_inrange_ff ? next_state.peak : '0;
      end
      if (ram_we) begin
         wr_addr_ff  <= s2_addr;
         wr_state_ff <= next_state;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_band_out    = rsp_band_ff;
   assign rsp_smoothed_db = rsp_smoothed_ff;
   assign rsp_peak_db     = rsp_peak_ff;

`ifndef SYNTH
   a_no_same_band_adjacent: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff && (s1_band_ff == s2_band_ff)))
      else $error("same band in read and update stages");

   a_write_feeds_output: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (rsp_valid_ff && (ADDR_W'(rsp_band_ff) == $past(s2_addr))))
      else $error("state write without matching result word");

   a_peak_not_below_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_peak_ff >= rsp_smoothed_ff))
      else $error("peak below smoothed level");

   a_bypass_entry_valid: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> bvld_ff[wr_addr_ff])
      else $error("bypassed entry not marked valid");
`endif

endmodule
